/* src/priority_greedy_capacity_allocator_assert.svh */
// Assertion macros shared by the allocator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef PRIORITY_GREEDY_CAPACITY_ALLOCATOR_ASSERT_SVH
`define PRIORITY_GREEDY_CAPACITY_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define PGCA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pgca assertion failed");
// next-cycle implication
`define PGCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pgca assertion failed");
`else
`define PGCA_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define PGCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* src/pgca_pkg.sv */
// Shared widths, register codes and pipeline control type for the allocator.
// No dependencies.
`default_nettype none
package pgca_pkg;

  localparam int DEF_NUM_CLIENTS = 4;

  localparam int REQ_W      = 10;
  localparam int CAP_W      = 10;
  localparam int PEN_W      = 7;
  localparam int REV_W      = 7;
  localparam int WEIGHT_W   = 8;
  localparam int BUDGET_W   = 10;
  localparam int TERMS_W    = 24;
  localparam int PR_W       = PEN_W + REQ_W;      // penalty * request
  localparam int WG_W       = WEIGHT_W + REQ_W;   // weight * grant
  localparam int TERM_W     = 20;                 // signed per-client profit term
  localparam int PROFIT_W   = 20;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = TERMS_W;

  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 10'd400;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIENT_BASE = 8'd1;

  // terms field positions
  localparam int CAP_LSB = 0;
  localparam int PEN_LSB = 10;
  localparam int REV_LSB = 17;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pgca_stage_en_t;

endpackage
`default_nettype wire

/* src/pgca_lane.sv */
// One client lane: clamp, ranking, prefix of earlier wants, grant and profit term.
// Depends on pgca_pkg.
`default_nettype none
module pgca_lane import pgca_pkg::*; #(
  parameter int NUM_CLIENTS = DEF_NUM_CLIENTS,
  parameter int LANE        = 0
) (
  input  wire logic                 clk_i,
  input  wire pgca_stage_en_t       en_i,
  input  wire logic [REQ_W-1:0]     req_i,
  input  wire logic [CAP_W-1:0]     cap_i,
  input  wire logic [PEN_W-1:0]     pen_i,
  input  wire logic [WEIGHT_W-1:0]  weights_i [NUM_CLIENTS],
  input  wire logic [REQ_W-1:0]     wants_i [NUM_CLIENTS],
  input  wire logic [BUDGET_W-1:0]  budget_i,
  output logic [REQ_W-1:0]          want_o,
  output logic [REQ_W-1:0]          grant_o,
  output logic signed [TERM_W-1:0]  term_o
);

  localparam int PrefixW = REQ_W + $clog2(NUM_CLIENTS);

  // stage 1
  logic [REQ_W-1:0]       want1_q;
  logic [WEIGHT_W-1:0]    weight1_q;
  logic [PR_W-1:0]        pr1_q;
  logic [NUM_CLIENTS-1:0] earlier1_q, earlier_d;
  // stage 2
  logic [REQ_W-1:0]       want2_q;
  logic [WEIGHT_W-1:0]    weight2_q;
  logic [PR_W-1:0]        pr2_q;
  logic                   first2_q;
  logic [PrefixW-1:0]     prefix2_q, prefix_d;
  // stage 3
  logic [REQ_W-1:0]       grant3_q, grant_d;
  logic                   served3_q, served_d;
  logic [WEIGHT_W-1:0]    weight3_q;
  logic [PR_W-1:0]        pr3_q;
  // stage 4
  logic [REQ_W-1:0]       grant4_q;
  logic signed [TERM_W-1:0] term4_q, term_d;

  logic [PrefixW:0]       need;
  logic [PrefixW:0]       budget_x;
  logic [PrefixW:0]       left;
  logic [WG_W-1:0]        wg;

  // a client precedes this lane on higher weight, or equal weight and lower index
  always_comb begin
    earlier_d = '0;
    for (int j = 0; j < NUM_CLIENTS; j++) begin
      if (j != LANE) begin
        earlier_d[j] = (weights_i[j] > weights_i[LANE]) ||
                       ((weights_i[j] == weights_i[LANE]) && (j < LANE));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      want1_q    <= (req_i > cap_i) ? cap_i : req_i;
      weight1_q  <= weights_i[LANE];
      pr1_q      <= PR_W'(pen_i) * PR_W'(req_i);
      earlier1_q <= earlier_d;
    end
  end

  always_comb begin
    prefix_d = '0;
    for (int j = 0; j < NUM_CLIENTS; j++) begin
      if (earlier1_q[j]) begin
        prefix_d = prefix_d + PrefixW'(wants_i[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      want2_q   <= want1_q;
      weight2_q <= weight1_q;
      pr2_q     <= pr1_q;
      first2_q  <= (earlier1_q == '0);
      prefix2_q <= prefix_d;
    end
  end

  // served when first or the budget exceeds the sum of earlier wants
  always_comb begin
    budget_x = (PrefixW+1)'(budget_i);
    need     = {1'b0, prefix2_q} + (PrefixW+1)'(want2_q);
    left     = budget_x - {1'b0, prefix2_q};
    served_d = first2_q || (budget_x > {1'b0, prefix2_q});
    if (!served_d) begin
      grant_d = '0;
    end else if (budget_x > need) begin
      grant_d = want2_q;
    end else begin
      grant_d = left[REQ_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      grant3_q  <= grant_d;
      served3_q <= served_d;
      weight3_q <= weight2_q;
      pr3_q     <= pr2_q;
    end
  end

  always_comb begin
    wg = WG_W'(weight3_q) * WG_W'(grant3_q);
    if (served3_q) begin
      term_d = $signed({{(TERM_W-WG_W){1'b0}}, wg}) -
               $signed({{(TERM_W-PR_W){1'b0}}, pr3_q});
    end else begin
      term_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      grant4_q <= grant3_q;
      term4_q  <= term_d;
    end
  end

  assign want_o  = want1_q;
  assign grant_o = grant4_q;
  assign term_o  = term4_q;

endmodule
`default_nettype wire

/* src/pgca_merge.sv */
// Merging stage: sums the lane profit terms, saturates, and holds the result beat.
// Depends on pgca_pkg.
`default_nettype none
module pgca_merge import pgca_pkg::*; #(
  parameter int NUM_CLIENTS = DEF_NUM_CLIENTS
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic [REQ_W-1:0]     grants_i [NUM_CLIENTS],
  input  wire logic signed [TERM_W-1:0] terms_i [NUM_CLIENTS],
  output logic [REQ_W-1:0]          grants_o [NUM_CLIENTS],
  output logic [PROFIT_W-1:0]       profit_o
);

  localparam int SumW = TERM_W + $clog2(NUM_CLIENTS);
  localparam logic signed [SumW-1:0] ProfitMax =
    {{(SumW-PROFIT_W+1){1'b0}}, {(PROFIT_W-1){1'b1}}};
  localparam logic signed [SumW-1:0] ProfitMin =
    {{(SumW-PROFIT_W+1){1'b1}}, {(PROFIT_W-1){1'b0}}};

  logic signed [SumW-1:0]  sum;
  logic [PROFIT_W-1:0]     profit_d, profit_q;
  logic [REQ_W-1:0]        grants_q [NUM_CLIENTS];

  always_comb begin
    sum = '0;
    for (int k = 0; k < NUM_CLIENTS; k++) begin
      sum = sum + $signed({{(SumW-TERM_W){terms_i[k][TERM_W-1]}}, terms_i[k]});
    end
    if (sum > ProfitMax) begin
      profit_d = ProfitMax[PROFIT_W-1:0];
    end else if (sum < ProfitMin) begin
      profit_d = ProfitMin[PROFIT_W-1:0];
    end else begin
      profit_d = sum[PROFIT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      profit_q <= profit_d;
      for (int k = 0; k < NUM_CLIENTS; k++) begin
        grants_q[k] <= grants_i[k];
      end
    end
  end

  assign grants_o = grants_q;
  assign profit_o = profit_q;

endmodule
`default_nettype wire

/* src/priority_greedy_capacity_allocator.sv */
// Priority greedy capacity allocator: one round of client requests per input beat
// is ranked by revenue plus penalty, granted greedily from the budget, and priced.
// Channels: s_axis (requests), m_axis (grants and round profit), cfg write port.
// Register 0 is the total budget; register 1 + k holds client k's cap, penalty and
// revenue. Other indexes are ignored. cfg_ready_o is always high; write only while
// no round is in flight.
// Pipeline: a round passes through five registers in all (four lane stages:
// clamp and rank, prefix sum of earlier wants, grant, profit multiply; then the
// lane-merging adder and output register).
// Throughput: one round per cycle while m_axis_tready stays high; every client
// has its own lane, so nothing in the pipeline is shared between rounds.
// Stall: when m_axis_tready is low the output beat holds; earlier stages keep
// filling empty slots, and s_axis_tready drops only once all five are full.
// Reset: budget returns to 400, client terms to zero, the pipeline empties.
`default_nettype none
module priority_greedy_capacity_allocator import pgca_pkg::*; #(
  parameter int NUM_CLIENTS = DEF_NUM_CLIENTS,
  localparam int InW  = ((NUM_CLIENTS*REQ_W + 7) / 8) * 8,
  localparam int OutW = ((NUM_CLIENTS*REQ_W + PROFIT_W + 7) / 8) * 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [InW-1:0]        s_axis_tdata,  // request_0 .. request_N-1
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OutW-1:0]            m_axis_tdata,  // grant_0 .. grant_N-1, round_profit
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

`include "priority_greedy_capacity_allocator_assert.svh"

  localparam int NumStages = 5;
  localparam int SumGW     = REQ_W + $clog2(NUM_CLIENTS);

  logic [BUDGET_W-1:0]  budget_q;
  logic [TERMS_W-1:0]   terms_q [NUM_CLIENTS];
  logic [NumStages-1:0] valid_q, valid_d;
  logic [NumStages-1:0] en;
  pgca_stage_en_t       lane_en;

  logic [WEIGHT_W-1:0]  weights [NUM_CLIENTS];
  logic [REQ_W-1:0]     wants [NUM_CLIENTS];
  logic [REQ_W-1:0]     lane_grants [NUM_CLIENTS];
  logic signed [TERM_W-1:0] lane_terms [NUM_CLIENTS];
  logic [REQ_W-1:0]     out_grants [NUM_CLIENTS];
  logic [PROFIT_W-1:0]  out_profit;
  logic [SumGW-1:0]     grant_sum;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= BUDGET_RESET;
      for (int k = 0; k < NUM_CLIENTS; k++) begin
        terms_q[k] <= '0;
      end
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_BUDGET) begin
        budget_q <= cfg_data_i[BUDGET_W-1:0];
      end
      for (int k = 0; k < NUM_CLIENTS; k++) begin
        if (cfg_index_i == CFG_CLIENT_BASE + CFG_IDX_W'(k)) begin
          terms_q[k] <= cfg_data_i[TERMS_W-1:0];
        end
      end
    end
  end

  // stage k loads when empty or when its contents move on
  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || m_axis_tready;
    for (int s = NumStages-2; s >= 0; s--) begin
      en[s] = !valid_q[s] || en[s+1];
    end
    valid_d = valid_q;
    if (en[0]) begin
      valid_d[0] = s_axis_tvalid;
    end
    for (int s = 1; s < NumStages; s++) begin
      if (en[s]) begin
        valid_d[s] = valid_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = valid_q[NumStages-1];

  assign lane_en.s1 = en[0];
  assign lane_en.s2 = en[1];
  assign lane_en.s3 = en[2];
  assign lane_en.s4 = en[3];

  always_comb begin
    for (int k = 0; k < NUM_CLIENTS; k++) begin
      weights[k] = WEIGHT_W'(terms_q[k][PEN_LSB +: PEN_W]) +
                   WEIGHT_W'(terms_q[k][REV_LSB +: REV_W]);
    end
  end

  for (genvar g = 0; g < NUM_CLIENTS; g++) begin : g_lane
    pgca_lane #(
      .NUM_CLIENTS (NUM_CLIENTS),
      .LANE        (g)
    ) u_lane (
      .clk_i     (clk_i),
      .en_i      (lane_en),
      .req_i     (s_axis_tdata[g*REQ_W +: REQ_W]),
      .cap_i     (terms_q[g][CAP_LSB +: CAP_W]),
      .pen_i     (terms_q[g][PEN_LSB +: PEN_W]),
      .weights_i (weights),
      .wants_i   (wants),
      .budget_i  (budget_q),
      .want_o    (wants[g]),
      .grant_o   (lane_grants[g]),
      .term_o    (lane_terms[g])
    );
  end

  pgca_merge #(
    .NUM_CLIENTS (NUM_CLIENTS)
  ) u_merge (
    .clk_i    (clk_i),
    .en_i     (en[NumStages-1]),
    .grants_i (lane_grants),
    .terms_i  (lane_terms),
    .grants_o (out_grants),
    .profit_o (out_profit)
  );

  always_comb begin
    m_axis_tdata = '0;
    grant_sum    = '0;
    for (int k = 0; k < NUM_CLIENTS; k++) begin
      m_axis_tdata[k*REQ_W +: REQ_W] = out_grants[k];
      grant_sum = grant_sum + SumGW'(out_grants[k]);
    end
    m_axis_tdata[NUM_CLIENTS*REQ_W +: PROFIT_W] = out_profit;
  end

  // granted capacity never exceeds the budget
  `PGCA_ASSERT_SAME(a_grant_within_budget, clk_i, rst_ni, m_axis_tvalid,
                    grant_sum <= SumGW'(budget_q))
  // a full pipeline with a stalled receiver takes no new round
  `PGCA_ASSERT_SAME(a_full_blocks_input, clk_i, rst_ni,
                    (&valid_q) && !m_axis_tready, !s_axis_tready)
  // an empty pipeline cannot present a result on the next cycle
  `PGCA_ASSERT_NEXT(a_no_skip, clk_i, rst_ni, valid_q == '0, !m_axis_tvalid)

endmodule
`default_nettype wire
